@@ hdl/slpc_pkg.sv @@
// shared types, codes and constants for the status led pattern controller
// no dependencies; used by status_led_pattern_controller
`default_nettype none

package slpc_pkg;

    // time and register widths
    localparam int TIME_BITS = 40;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = $clog2(TIME_BITS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 1'b1;

    localparam logic [CFG_W-1:0] BLINK_RESET = 16'd250;
    localparam logic [CFG_W-1:0] PULSE_RESET = 16'd1000;

    // colours
    localparam logic [1:0] COL_OFF   = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_AMBER = 2'd2;
    localparam logic [1:0] COL_GREEN = 2'd3;

    // rhythms
    localparam logic [1:0] RH_STEADY = 2'd0;
    localparam logic [1:0] RH_PULSE  = 2'd1;
    localparam logic [1:0] RH_BLINK  = 2'd2;

    // power states
    localparam logic [2:0] PS_CHARGED  = 3'd1;
    localparam logic [2:0] PS_CHARGING = 3'd2;
    localparam logic [2:0] PS_EXT_IDLE = 3'd3;
    localparam logic [2:0] PS_LOW      = 3'd4;
    localparam logic [2:0] PS_CRITICAL = 3'd5;
    localparam logic [2:0] PS_FAULT    = 3'd6;

    // burst lengths in blinks
    localparam logic [1:0] CNT_CRITICAL = 2'd3;
    localparam logic [1:0] CNT_LOW      = 2'd1;

    typedef enum logic [1:0] {
        FN_SET_POWER  = 2'd0,
        FN_SET_PORTAL = 2'd1,
        FN_SET_ACT    = 2'd2,
        FN_QUERY      = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARM,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_func                func;
        logic [2:0]           power_state;
        logic                 rearm;
        logic                 flag_value;
        logic [TIME_BITS-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0] shown_colour;
        logic [1:0] pattern_colour;
        logic [1:0] rhythm;
        logic [1:0] blinks_left;
    } t_out_item;

    typedef struct packed {
        logic [1:0] colour;
        logic [1:0] rhythm;
    } t_steady;

    // steady pattern by priority: fault, busy, portal, power state
    function automatic t_steady pick_steady(input logic [2:0] power,
                                            input logic       busy,
                                            input logic       portal);
        t_steady s;
        s.rhythm = RH_STEADY;
        s.colour = COL_OFF;
        if (power == PS_FAULT) begin
            s.colour = COL_RED;
            s.rhythm = RH_PULSE;
        end else if (busy) begin
            s.colour = COL_GREEN;
            s.rhythm = RH_PULSE;
        end else if (portal) begin
            s.colour = COL_AMBER;
        end else if (power == PS_CHARGED) begin
            s.colour = COL_GREEN;
        end else if (power == PS_CHARGING) begin
            s.colour = COL_RED;
        end else if (power == PS_EXT_IDLE) begin
            s.colour = COL_AMBER;
            s.rhythm = RH_PULSE;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/status_led_pattern_controller.sv @@
// status led pattern controller: set items, burst arming, serial divider for phases
// depends on slpc_pkg for item types, codes and constants
`default_nettype none

// Set items (power state, portal flag, busy flag) update the recorded status and
// give no result. A query item runs through these steps: ARM starts an armed
// burst, CMP compares the query time with the burst window, then TIME_BITS
// steps of a one-bit-per-cycle restoring divider give the blink phase
// (elapsed / half period) or the pulse phase (time % period), and DONE loads
// the result register once it is empty or being taken. The result register
// lets set items be accepted while a result still waits to be taken.
// Configuration writes land at once and are meant for idle times.
module status_led_pattern_controller (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // input items
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  slpc_pkg::t_in_item                    i_in,
    // result items
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output slpc_pkg::t_out_item                   o_out,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire  [slpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [slpc_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int TB   = slpc_pkg::TIME_BITS;
    localparam int CW   = slpc_pkg::CFG_W;
    localparam int LENW = CW + 3;  // three blinks of two halves each

    // control
    slpc_pkg::t_state r_state, n_state;
    logic             w_in_acc;
    logic             w_out_load;

    // configuration
    logic [CW-1:0] r_blink;
    logic [CW-1:0] r_pulse;

    // recorded status
    logic [2:0] r_power;
    logic       r_portal;
    logic       r_busy;
    logic       r_armed;
    logic [1:0] r_arm_col;
    logic [1:0] r_arm_cnt;
    logic [1:0] r_burst_col;
    logic [1:0] r_burst_cnt;
    logic [TB-1:0] r_start;
    logic [TB:0]   r_end;

    // query datapath
    logic [TB-1:0]                 r_now;
    logic                          r_active;
    logic [TB-1:0]                 r_dvd;
    logic [CW-1:0]                 r_dvsr;
    logic [CW-1:0]                 r_rem;
    logic [2:0]                    r_q_lo;
    logic                          r_q_hi;
    logic [slpc_pkg::CNT_W-1:0]    r_cnt;

    // result register
    logic                 r_out_valid;
    slpc_pkg::t_out_item  r_out;

    // combinational helpers
    logic [CW-1:0]   w_blink_eff;
    logic [CW-1:0]   w_pulse_eff;
    logic [CW:0]     w_two_b;
    logic [LENW-1:0] w_len;
    logic            w_active;
    logic [TB:0]     w_diff;
    logic [TB-1:0]   w_elapsed;
    logic [CW:0]     w_trial;
    logic            w_ge;
    logic [CW:0]     w_sub;
    logic [1:0]      w_done;
    slpc_pkg::t_steady   w_steady;
    slpc_pkg::t_out_item w_result;

    assign o_in_ready  = (r_state == slpc_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == slpc_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a zero register acts as one
    assign w_blink_eff = (r_blink == '0) ? CW'(1) : r_blink;
    assign w_pulse_eff = (r_pulse == '0) ? CW'(1) : r_pulse;

    // burst length = count * 2 * half period, count is at most three
    assign w_two_b = {w_blink_eff, 1'b0};
    assign w_len   = ({2'b00, w_two_b} & {LENW{r_arm_cnt[0]}})
                   + ({1'b0, w_two_b, 1'b0} & {LENW{r_arm_cnt[1]}});

    // burst window check; the end carries one extra bit so it never wraps
    assign w_active  = ({1'b0, r_now} < r_end);
    assign w_diff    = {1'b0, r_now} - {1'b0, r_start};
    // time running backwards counts as nothing elapsed
    assign w_elapsed = w_diff[TB] ? '0 : w_diff[TB-1:0];

    // one restoring divider step: bring down the next dividend bit
    assign w_trial = {r_rem, r_dvd[TB-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvsr});
    assign w_sub   = w_trial - {1'b0, r_dvsr};

    // completed blinks are the quotient without its phase bit
    assign w_done  = r_q_lo[2:1];
    assign w_steady = slpc_pkg::pick_steady(r_power, r_busy, r_portal);

    always_comb begin
        w_result = '0;
        if (r_active) begin
            w_result.pattern_colour = r_burst_col;
            w_result.rhythm         = slpc_pkg::RH_BLINK;
            // odd half periods are the off halves
            w_result.shown_colour   = r_q_lo[0] ? slpc_pkg::COL_OFF : r_burst_col;
            // saturate when the half period was lowered mid-burst
            if (!r_q_hi && (w_done < r_burst_cnt)) begin
                w_result.blinks_left = r_burst_cnt - w_done;
            end
        end else begin
            w_result.pattern_colour = w_steady.colour;
            w_result.rhythm         = w_steady.rhythm;
            w_result.shown_colour   = w_steady.colour;
            // pulse is on during the first half of its period
            if (w_steady.rhythm == slpc_pkg::RH_PULSE && r_rem >= (r_dvsr >> 1)) begin
                w_result.shown_colour = slpc_pkg::COL_OFF;
            end
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slpc_pkg::ST_IDLE: begin
                if (w_in_acc && i_in.func == slpc_pkg::FN_QUERY) begin
                    n_state = slpc_pkg::ST_ARM;
                end
            end
            slpc_pkg::ST_ARM: begin
                n_state = slpc_pkg::ST_CMP;
            end
            slpc_pkg::ST_CMP: begin
                n_state = slpc_pkg::ST_DIV;
            end
            slpc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = slpc_pkg::ST_DONE;
                end
            end
            slpc_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = slpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slpc_pkg::ST_IDLE;
            end
        endcase
    end

    // status, configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink     <= slpc_pkg::BLINK_RESET;
            r_pulse     <= slpc_pkg::PULSE_RESET;
            r_power     <= '0;
            r_portal    <= 1'b0;
            r_busy      <= 1'b0;
            r_armed     <= 1'b0;
            r_arm_col   <= '0;
            r_arm_cnt   <= '0;
            r_burst_col <= '0;
            r_burst_cnt <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    slpc_pkg::REG_BLINK_HALF: r_blink <= i_cfg_data;
                    slpc_pkg::REG_PULSE:      r_pulse <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_in_acc) begin
                case (i_in.func)
                    slpc_pkg::FN_SET_POWER: begin
                        r_power <= i_in.power_state;
                        // entering, or refreshing, a warning state arms a burst
                        if (i_in.power_state != r_power || i_in.rearm) begin
                            if (i_in.power_state == slpc_pkg::PS_CRITICAL) begin
                                r_armed   <= 1'b1;
                                r_arm_col <= slpc_pkg::COL_RED;
                                r_arm_cnt <= slpc_pkg::CNT_CRITICAL;
                            end else if (i_in.power_state == slpc_pkg::PS_LOW) begin
                                r_armed   <= 1'b1;
                                r_arm_col <= slpc_pkg::COL_AMBER;
                                r_arm_cnt <= slpc_pkg::CNT_LOW;
                            end
                        end
                    end
                    slpc_pkg::FN_SET_PORTAL: r_portal <= i_in.flag_value;
                    slpc_pkg::FN_SET_ACT:    r_busy   <= i_in.flag_value;
                    default: begin
                    end
                endcase
            end

            // an armed burst starts at the query time, replacing any running one
            if (r_state == slpc_pkg::ST_ARM && r_armed) begin
                r_armed     <= 1'b0;
                r_burst_col <= r_arm_col;
                r_burst_cnt <= r_arm_cnt;
                r_start     <= r_now;
                r_end       <= {1'b0, r_now} + {{(TB + 1 - LENW){1'b0}}, w_len};
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query datapath and serial divider
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now <= i_in.now_ms;
        end
        case (r_state)
            slpc_pkg::ST_CMP: begin
                r_active <= w_active;
                r_dvd    <= w_active ? w_elapsed : r_now;
                r_dvsr   <= w_active ? w_blink_eff : w_pulse_eff;
                r_rem    <= '0;
                r_q_lo   <= '0;
                r_q_hi   <= 1'b0;
                r_cnt    <= slpc_pkg::CNT_W'(TB - 1);
            end
            slpc_pkg::ST_DIV: begin
                r_rem  <= w_ge ? w_sub[CW-1:0] : w_trial[CW-1:0];
                r_dvd  <= {r_dvd[TB-2:0], 1'b0};
                r_q_lo <= {r_q_lo[1:0], w_ge};
                r_q_hi <= r_q_hi | r_q_lo[2];
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

`ifndef SYNTHESIS
    // a query moves straight on to burst start
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.func == slpc_pkg::FN_QUERY) |=> (r_state == slpc_pkg::ST_ARM))
        else $error("query item did not start the sequencer");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slpc_pkg::ST_DIV) |-> (r_rem < r_dvsr))
        else $error("divider remainder out of range");

    // burst start consumes the armed burst
    a_arm_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slpc_pkg::ST_ARM) |=> !r_armed)
        else $error("armed burst not consumed at query");

    // a running burst always has a window past its start
    a_burst_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slpc_pkg::ST_DONE && r_active) |-> (r_end > {1'b0, r_start}))
        else $error("burst active with empty window");
`endif

endmodule

`default_nettype wire
